FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is muted while reset is high.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent check that also runs through reset.
`define ASSERT_THROUGH_RESET(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: sv/i2cram_pkg.sv
`default_nettype none

package i2cram_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_MULTI = 2'd3
   } opcode_type;

   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_BUS_BUSY   = 3'd1;
   localparam logic [2:0] STAT_START_ERR  = 3'd2;
   localparam logic [2:0] STAT_ADDR_NACK  = 3'd3;
   localparam logic [2:0] STAT_ZERO_COUNT = 3'd4;

   typedef enum logic [14:0] {
      ST_IDLE      = 15'b000000000000001,
      ST_START     = 15'b000000000000010,
      ST_SEND_WA   = 15'b000000000000100,
      ST_ACK_WA    = 15'b000000000001000,
      ST_SEND_REG  = 15'b000000000010000,
      ST_ACK_REG   = 15'b000000000100000,
      ST_SEND_DATA = 15'b000000001000000,
      ST_ACK_DATA  = 15'b000000010000000,
      ST_RSTART    = 15'b000000100000000,
      ST_SEND_RA   = 15'b000001000000000,
      ST_ACK_RA    = 15'b000010000000000,
      ST_READ      = 15'b000100000000000,
      ST_STOP      = 15'b001000000000000,
      ST_MACK      = 15'b010000000000000,
      ST_STOP_FAIL = 15'b100000000000000
   } step_type;

   typedef enum logic [2:0] {
      CL_START = 3'd0,
      CL_SEND  = 3'd1,
      CL_WACK  = 3'd2,
      CL_READ  = 3'd3,
      CL_MACK  = 3'd4,
      CL_STOP  = 3'd5,
      CL_NONE  = 3'd6
   } class_type;

   typedef struct packed {
      opcode_type opcode;
      logic [7:0] slave_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic [7:0] read_count;
      logic       sda_sample;
   } item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       byte_valid;
      logic [7:0] read_byte;
      logic       last_byte;
      logic       done_res;
      logic [2:0] status;
   } result_type;

   function automatic class_type step_class(step_type step);
      class_type cls;
      case (step)
         ST_START, ST_RSTART: cls = CL_START;
         ST_SEND_WA, ST_SEND_REG, ST_SEND_DATA, ST_SEND_RA: cls = CL_SEND;
         ST_ACK_WA, ST_ACK_REG, ST_ACK_DATA, ST_ACK_RA: cls = CL_WACK;
         ST_READ: cls = CL_READ;
         ST_MACK: cls = CL_MACK;
         ST_STOP, ST_STOP_FAIL: cls = CL_STOP;
         default: cls = CL_NONE;
      endcase
      return cls;
   endfunction

   // pin levels on entry to a sub-phase; returns {scl, sda}
   function automatic logic [1:0] apply_pins(step_type step, logic [1:0] sub, logic msb,
                                             logic more, logic scl, logic sda);
      class_type cls;
      logic      s_scl;
      logic      s_sda;
      cls   = step_class(step);
      s_scl = scl;
      s_sda = sda;
      case (cls)
         CL_START: begin
            if (sub == 2'd0) begin
               s_scl = 1'b1;
               s_sda = 1'b1;
            end else begin
               s_sda = 1'b0;
            end
         end
         CL_SEND: begin
            if (sub == 2'd0) s_scl = 1'b0;
            else if (sub == 2'd1) s_sda = msb;
            else s_scl = 1'b1;
         end
         CL_READ: begin
            if (sub == 2'd0) begin
               s_scl = 1'b0;
               s_sda = 1'b1;
            end else begin
               s_scl = 1'b1;
            end
         end
         CL_WACK, CL_MACK: begin
            if (sub == 2'd0) s_scl = 1'b0;
            else if (sub == 2'd1) s_sda = !(cls == CL_MACK && more);
            else if (sub == 2'd2) s_scl = 1'b1;
            else s_scl = 1'b0;
         end
         CL_STOP: begin
            if (sub == 2'd0) s_scl = 1'b0;
            else if (sub == 2'd1) s_sda = 1'b0;
            else if (sub == 2'd2) s_scl = 1'b1;
            else s_sda = 1'b1;
         end
         default: begin
            s_scl = scl;
            s_sda = sda;
         end
      endcase
      return {s_scl, s_sda};
   endfunction

endpackage

`default_nettype wire

FILE: sv/i2cram_in_stage.sv
`default_nettype none

module i2cram_in_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [39:0]         req_tdata,
   input  wire logic [1:0]          req_tuser,
   input  wire logic                take,
   output logic                     item_valid,
   output i2cram_pkg::item_type     item
);
   import i2cram_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) valid_in = 1'b1;
      else if (take) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.opcode           <= opcode_type'(req_tuser);
         item_ff.slave_address    <= req_tdata[7:0];
         item_ff.register_address <= req_tdata[15:8];
         item_ff.write_data       <= req_tdata[23:16];
         item_ff.read_count       <= req_tdata[31:24];
         item_ff.sda_sample       <= req_tdata[32];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: sv/i2cram_seq.sv
`default_nettype none

module i2cram_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [15:0]            csr_wdata,
   input  wire logic                   item_valid,
   input  wire i2cram_pkg::item_type   item,
   output logic                        take,
   input  wire logic                   out_free,
   output logic                        out_load,
   output i2cram_pkg::result_type      result
);
   import i2cram_pkg::*;

   logic [15:0] phase_len_ff;
   step_type    step_ff, step_in;
   logic [1:0]  sub_ff, sub_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  bytes_ff, bytes_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  slave_ff, slave_in;
   logic [7:0]  reg_ff, reg_in;
   logic [7:0]  data_ff, data_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;

   class_type   cls;
   step_type    follow;
   step_type    target;
   logic        enter;
   logic        apply;
   logic        fin;
   logic [2:0]  fin_status;
   logic        emit;
   logic [15:0] t_next;
   logic [7:0]  shift_rx;
   result_type  res;

   assign take = item_valid && out_free;

   // successor of each step when its last sub-phase ends
   always_comb begin
      case (step_ff)
         ST_START:     follow = ST_SEND_WA;
         ST_SEND_WA:   follow = ST_ACK_WA;
         ST_ACK_WA:    follow = (bit_ff != 4'd0) ? ST_STOP_FAIL : ST_SEND_REG;
         ST_SEND_REG:  follow = ST_ACK_REG;
         ST_ACK_REG:   follow = (kind_ff == OP_WRITE) ? ST_SEND_DATA : ST_RSTART;
         ST_SEND_DATA: follow = ST_ACK_DATA;
         ST_ACK_DATA:  follow = ST_STOP;
         ST_RSTART:    follow = ST_SEND_RA;
         ST_SEND_RA:   follow = ST_ACK_RA;
         ST_ACK_RA:    follow = ST_READ;
         ST_READ:      follow = ST_MACK;
         ST_MACK:      follow = (bytes_ff > 8'd1) ? ST_READ : ST_STOP;
         default:      follow = ST_IDLE;
      endcase
   end

   always_comb begin
      step_in    = step_ff;
      sub_in     = sub_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      bytes_in   = bytes_ff;
      kind_in    = kind_ff;
      slave_in   = slave_ff;
      reg_in     = reg_ff;
      data_in    = data_ff;
      ticks_in   = ticks_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      res        = '0;
      res.scl_level = scl_ff;
      res.sda_level = sda_ff;
      emit       = 1'b0;
      enter      = 1'b0;
      apply      = 1'b0;
      fin        = 1'b0;
      fin_status = STAT_OK;
      target     = follow;
      cls        = step_class(step_ff);
      t_next     = ticks_ff + 16'd1;
      shift_rx   = {shift_ff[6:0], item.sda_sample};

      if (take) begin
         if (item.opcode != OP_TICK) begin
            if (step_ff == ST_IDLE) begin
               if (item.opcode == OP_MULTI && item.read_count == 8'd0) begin
                  emit       = 1'b1;
                  fin        = 1'b1;
                  fin_status = STAT_ZERO_COUNT;
               end else begin
                  kind_in  = item.opcode;
                  slave_in = item.slave_address;
                  reg_in   = item.register_address;
                  data_in  = item.write_data;
                  bytes_in = (item.opcode == OP_MULTI) ? item.read_count : 8'd1;
                  ticks_in = 16'd0;
                  enter    = 1'b1;
                  target   = ST_START;
               end
            end
         end else begin
            emit = 1'b1;
            if (step_ff != ST_IDLE) begin
               if (t_next >= phase_len_ff) begin
                  ticks_in = 16'd0;
                  case (cls)
                     CL_START: begin
                        if (step_ff == ST_START && sub_ff == 2'd0 && !item.sda_sample) begin
                           fin        = 1'b1;
                           fin_status = STAT_BUS_BUSY;
                        end else if (step_ff == ST_START && sub_ff == 2'd1 &&
                                     item.sda_sample) begin
                           fin        = 1'b1;
                           fin_status = STAT_START_ERR;
                        end else if (sub_ff < 2'd2) begin
                           sub_in = sub_ff + 2'd1;
                           apply  = 1'b1;
                        end else begin
                           enter = 1'b1;
                        end
                     end
                     CL_SEND: begin
                        if (sub_ff < 2'd2) begin
                           sub_in = sub_ff + 2'd1;
                           apply  = 1'b1;
                        end else begin
                           shift_in = {shift_ff[6:0], 1'b0};
                           bit_in   = bit_ff + 4'd1;
                           if (bit_ff >= 4'd7) begin
                              enter = 1'b1;
                           end else begin
                              sub_in = 2'd0;
                              apply  = 1'b1;
                           end
                        end
                     end
                     CL_WACK: begin
                        // hold the ack sample in the bit counter for the next decision
                        if (sub_ff == 2'd2) bit_in = {3'b000, item.sda_sample};
                        if (sub_ff < 2'd3) begin
                           sub_in = sub_ff + 2'd1;
                           apply  = 1'b1;
                        end else begin
                           enter = 1'b1;
                        end
                     end
                     CL_READ: begin
                        if (sub_ff == 2'd0) begin
                           sub_in = 2'd1;
                           apply  = 1'b1;
                        end else begin
                           shift_in = shift_rx;
                           bit_in   = bit_ff + 4'd1;
                           if (bit_ff >= 4'd7) begin
                              res.byte_valid = 1'b1;
                              res.read_byte  = shift_rx;
                              res.last_byte  = (bytes_ff <= 8'd1);
                              enter          = 1'b1;
                           end else begin
                              sub_in = 2'd0;
                              apply  = 1'b1;
                           end
                        end
                     end
                     CL_MACK: begin
                        if (sub_ff < 2'd3) begin
                           sub_in = sub_ff + 2'd1;
                           apply  = 1'b1;
                        end else begin
                           if (bytes_ff > 8'd1) bytes_in = bytes_ff - 8'd1;
                           enter = 1'b1;
                        end
                     end
                     CL_STOP: begin
                        if (sub_ff < 2'd3) begin
                           sub_in = sub_ff + 2'd1;
                           apply  = 1'b1;
                        end else begin
                           fin        = 1'b1;
                           fin_status = (step_ff == ST_STOP_FAIL) ? STAT_ADDR_NACK : STAT_OK;
                        end
                     end
                     default: begin
                        fin = 1'b0;
                     end
                  endcase
               end else begin
                  ticks_in = t_next;
               end
            end
         end
      end

      if (enter) begin
         step_in = target;
         sub_in  = 2'd0;
         bit_in  = 4'd0;
         case (target)
            ST_SEND_WA:   shift_in = slave_ff;
            ST_SEND_REG:  shift_in = reg_ff;
            ST_SEND_DATA: shift_in = data_ff;
            ST_SEND_RA:   shift_in = slave_ff + 8'd1;
            ST_READ:      shift_in = 8'd0;
            default:      shift_in = shift_in;
         endcase
         apply = 1'b1;
      end

      if (apply) begin
         {scl_in, sda_in} = apply_pins(step_in, sub_in, shift_in[7], (bytes_in > 8'd1),
                                       scl_ff, sda_ff);
      end

      if (fin) begin
         step_in        = ST_IDLE;
         sub_in         = 2'd0;
         bit_in         = 4'd0;
         scl_in         = 1'b1;
         sda_in         = 1'b1;
         res.done_res   = 1'b1;
         res.status     = fin_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_len_ff <= 16'd1;
      end else if (csr_we) begin
         phase_len_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_IDLE;
         sub_ff   <= 2'd0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         bytes_ff <= 8'd0;
         kind_ff  <= 2'd0;
         slave_ff <= 8'd0;
         reg_ff   <= 8'd0;
         data_ff  <= 8'd0;
         ticks_ff <= 16'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
      end else begin
         step_ff  <= step_in;
         sub_ff   <= sub_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         bytes_ff <= bytes_in;
         kind_ff  <= kind_in;
         slave_ff <= slave_in;
         reg_ff   <= reg_in;
         data_ff  <= data_in;
         ticks_ff <= ticks_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
      end
   end

   assign out_load = take && emit;
   assign result   = res;

endmodule

`default_nettype wire

FILE: sv/i2cram_out_stage.sv
`default_nettype none

module i2cram_out_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    out_load,
   input  wire i2cram_pkg::result_type  result,
   output logic                         out_free,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [15:0]                  rsp_tdata,
   output logic [0:0]                   rsp_tuser,
   output logic                         rsp_tlast
);
   import i2cram_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (out_load) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) result_ff <= result;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, result_ff.status, result_ff.done_res, result_ff.read_byte,
                        result_ff.sda_level, result_ff.scl_level};
   assign rsp_tuser  = result_ff.byte_valid;
   assign rsp_tlast  = result_ff.last_byte;

endmodule

`default_nettype wire

FILE: sv/i2c_register_access_master_unit.sv
`default_nettype none

// I2C register-access master. A command item (tuser 1 single write, 2 single read,
// 3 multi read) latches a transaction and returns no result, except a multi read with
// a zero count, which returns one finished result with status 4 at once; a command
// that arrives while a transaction runs is dropped. Each tick item (tuser 0) carries
// the sampled SDA level and returns exactly one result holding the SCL/SDA drive
// levels for that tick, plus a received byte (tuser, tlast) and done/status when a
// byte completes or the transaction ends. Every phase of the bus lasts csr_wdata
// ticks as last written (reset 1, zero acts as one). The block takes one item per
// clock cycle while results are taken; the sequencer works on the item in the input
// register and loads the result register at the next edge, so a result passes the
// input and result registers. A held-off result stalls the sequencer, and the
// input register then fills and drops req_tready. Write the phase length only while
// no transaction is running.
module i2c_register_access_master_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,     // phase_length
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] slave_address, [15:8] register_address, [23:16] write_data,
   // [31:24] read_count, [32] sda_sample, [39:33] zero
   input  wire logic [39:0] req_tdata,
   input  wire logic [1:0]  req_tuser,     // [1:0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] scl_level, [1] sda_level, [9:2] read_byte, [10] done_res,
   // [13:11] status, [15:14] zero
   output logic [15:0]      rsp_tdata,
   output logic [0:0]       rsp_tuser,     // [0] byte_valid
   output logic             rsp_tlast      // last_byte
);
   import i2cram_pkg::*;

   logic        take;
   logic        item_valid;
   item_type    item;
   logic        out_load;
   logic        out_free;
   result_type  result;

   i2cram_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cram_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .out_free   (out_free),
      .out_load   (out_load),
      .result     (result)
   );

   i2cram_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .out_load   (out_load),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: sv/i2cram_checker.sv
`default_nettype none

`include "assert_macros.svh"

module i2cram_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        csr_we,
   input wire logic [15:0] csr_wdata,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [39:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // a stalled result item keeps its payload
   `ASSERT_ALWAYS(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // status only with done, and only defined codes
   `ASSERT_ALWAYS(a_status_done, clock, reset, rsp_tvalid |-> (rsp_tdata[10] || rsp_tdata[13:11] == 3'd0) && rsp_tdata[13:11] <= 3'd4)

   // no byte: read_byte and tlast stay clear
   `ASSERT_ALWAYS(a_byte_clear, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[9:2] == 8'd0 && !rsp_tlast)

   // reset empties both registers
   `ASSERT_THROUGH_RESET(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind i2c_register_access_master_unit i2cram_checker u_checker (.*);

`default_nettype wire
